/* hw/rtl/dpd_pkg.sv */
// Shared types, constants and Q8.24 arithmetic helpers for the DPD pair update.
// Used by dpd_fdiv and dpd_pair_velocity_update_unit.
`default_nettype none

package dpd_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    localparam logic signed [31:0] FX_ONE  = 32'sh0100_0000;
    localparam logic signed [31:0] FX_HALF = 32'sh0080_0000;
    localparam logic signed [31:0] FX_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] FX_MIN  = 32'sh8000_0000;

    localparam logic signed [39:0] SAT_HI40 = 40'sh00_7FFF_FFFF;
    localparam logic signed [39:0] SAT_LO40 = 40'shFF_8000_0000;
    localparam logic signed [63:0] RND_HALF = 64'sh0000_0000_0080_0000;

    typedef enum logic [2:0] {
        CFG_CUTOFF_SQ         = 3'd0,
        CFG_CUTOFF            = 3'd1,
        CFG_NOISE_AMPLITUDE   = 3'd2,
        CFG_TIME_STEP         = 3'd3,
        CFG_TIME_STEP_ROOT    = 3'd4,
        CFG_INV_TEMPERATURE   = 3'd5,
        CFG_INV_BOLTZMANN     = 3'd6,
        CFG_FORCE_TO_VELOCITY = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] sep_x;
        logic signed [31:0] sep_y;
        logic signed [31:0] sep_z;
        logic signed [31:0] vel_ix;
        logic signed [31:0] vel_iy;
        logic signed [31:0] vel_iz;
        logic signed [31:0] vel_jx;
        logic signed [31:0] vel_jy;
        logic signed [31:0] vel_jz;
        logic [30:0]        inv_mass_i;
        logic [30:0]        inv_mass_j;
        logic signed [31:0] gauss_sample;
    } pair_t;

    typedef struct packed {
        logic signed [31:0] new_ix;
        logic signed [31:0] new_iy;
        logic signed [31:0] new_iz;
        logic signed [31:0] new_jx;
        logic signed [31:0] new_jy;
        logic signed [31:0] new_jz;
        logic               interacted;
    } result_t;

    typedef logic [2:0][31:0] vec3_t;

    typedef struct packed {
        vec3_t vi;
        vec3_t vj;
    } vel_t;

    typedef struct packed {
        logic [30:0] mi;
        logic [30:0] mj;
        logic [31:0] g;
        logic        hit;
    } side_t;

    typedef struct packed {
        logic adv;
    } pipe_ctrl_t;

    function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI40) begin
            r = FX_MAX;
        end
        else if (v < SAT_LO40) begin
            r = FX_MIN;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = $signed({a[31], a}) + $signed({b[31], b});
        return sat40({{7{s[32]}}, s});
    endfunction

    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = $signed({a[31], a}) - $signed({b[31], b});
        return sat40({{7{s[32]}}, s});
    endfunction

    function automatic logic signed [31:0] sum3_sat(input logic signed [31:0] a,
                                                    input logic signed [31:0] b,
                                                    input logic signed [31:0] c);
        logic signed [33:0] s;
        s = $signed({{2{a[31]}}, a}) + $signed({{2{b[31]}}, b})
            + $signed({{2{c[31]}}, c});
        return sat40({{6{s[33]}}, s});
    endfunction

    // round half up, then clamp
    function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        p = p + RND_HALF;
        return sat40(p[63:24]);
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] a);
        logic [31:0] r;
        r = a[31] ? 32'(-a) : a;
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/dpd_pair_velocity_update_unit.sv */
// DPD pair velocity update, Shardlow splitting, Q8.24 fixed point.
// Depends on dpd_pkg and dpd_fdiv.
//
// Takes one neighbour pair per clock while the result port is not stalled and
// returns its updated velocities, with interacted set when the squared distance
// is nonzero and below cutoff_sq. The latency is set by the 32-step square root,
// the quotient units for the pair axis and r/cutoff, and the reciprocal of the
// implicit correction that the second stage of the update waits on. A stall at
// the result port holds the whole pipeline. Register writes belong only to
// times when no pair is in flight.
`default_nettype none

module dpd_pair_velocity_update_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pair_valid,
    output logic                  pair_stall,
    input  wire dpd_pkg::pair_t   pair,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output dpd_pkg::result_t      result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [30:0]      cfg_data
);

    localparam int ST_SQ    = 1;
    localparam int ST_RSQ   = 2;
    localparam int ST_ROOT  = ST_RSQ + dpd_pkg::SQRT_STEPS;
    localparam int DIV_LAT  = dpd_pkg::DIV_STEPS + 1;
    localparam int ST_NDIV  = ST_ROOT + DIV_LAT;
    localparam int ST_N     = ST_NDIV + 1;
    localparam int ST_W1    = ST_N + 1;
    localparam int ST_W2    = ST_W1 + 1;
    localparam int ST_W3    = ST_W2 + 1;
    localparam int ST_GF    = ST_W3 + 1;
    localparam int ST_A0    = ST_GF + 1;
    localparam int ST_A1    = ST_A0 + 1;
    localparam int ST_A2    = ST_A1 + 1;
    localparam int ST_A3    = ST_A2 + 1;
    localparam int ST_A4    = ST_A3 + 1;
    localparam int ST_B0    = ST_A4 + 1;
    localparam int ST_B1    = ST_B0 + 1;
    localparam int ST_B2    = ST_B1 + 1;
    localparam int ST_B3    = ST_B2 + 1;
    localparam int ST_B4    = ST_B3 + 1;
    localparam int ST_CDIV  = ST_A1 + DIV_LAT;
    localparam int ST_FB    = ST_CDIV + 1;
    localparam int ST_B5    = ST_FB + 1;
    localparam int ST_B6    = ST_B5 + 1;
    localparam int ST_OUT   = ST_B6 + 1;

    dpd_pkg::pipe_ctrl_t ctrl;
    logic                adv;

    logic [ST_OUT:0] valid_reg;

    logic [30:0] cutoff_sq_reg;
    logic [30:0] cutoff_reg;
    logic [30:0] noise_reg;
    logic [30:0] dt_reg;
    logic [30:0] dt_root_reg;
    logic [30:0] inv_temp_reg;
    logic [30:0] inv_kb_reg;
    logic [30:0] f2v_reg;

    logic signed [31:0] hs_reg;
    logic signed [31:0] hs2_reg;
    logic signed [31:0] hgk_reg;
    logic signed [31:0] hg_reg;

    dpd_pkg::vec3_t d_reg    [0:ST_ROOT];
    dpd_pkg::vel_t  vel_reg  [0:ST_A3];
    dpd_pkg::side_t side_reg [0:ST_B6];

    logic [63:0] sq_reg [3];
    logic [63:0] rsq_next;
    logic        hit_next;

    logic [32:0] sq_rem_reg  [0:dpd_pkg::SQRT_STEPS];
    logic [31:0] sq_root_reg [0:dpd_pkg::SQRT_STEPS];
    logic [63:0] sq_v_reg    [0:dpd_pkg::SQRT_STEPS];
    logic [32:0] sq_rem_next  [1:dpd_pkg::SQRT_STEPS];
    logic [31:0] sq_root_next [1:dpd_pkg::SQRT_STEPS];

    dpd_pkg::vec3_t     n_quo;
    logic signed [31:0] q_quo;
    logic signed [31:0] c_quo;

    dpd_pkg::vec3_t     n_reg  [ST_N:ST_FB];
    logic signed [31:0] sr_reg [ST_GF:ST_B3];
    logic signed [31:0] gf_reg [ST_GF:ST_B2];
    logic signed [31:0] sb_reg [ST_B4:ST_CDIV];
    dpd_pkg::vel_t      v1_reg [ST_A4:ST_B6];

    logic signed [31:0] wr_reg;
    logic signed [31:0] ww_reg;
    logic signed [31:0] hsw_reg;
    logic signed [31:0] wdt_reg;
    logic signed [31:0] hswt_reg;
    logic signed [31:0] hgw_reg;
    logic signed [31:0] hswtf_reg;
    logic signed [31:0] dota_reg;
    logic signed [31:0] dota2_reg;
    logic signed [31:0] mgf_reg;
    logic signed [31:0] fga_reg;
    logic signed [31:0] den_reg;
    logic signed [31:0] fa_reg;
    logic signed [31:0] dotb_reg;
    logic signed [31:0] fgb_reg;
    logic signed [31:0] fb_reg;
    dpd_pkg::vec3_t     dv_reg;
    dpd_pkg::vec3_t     pa_reg;
    dpd_pkg::vec3_t     nfa_reg;
    dpd_pkg::vec3_t     aia_reg;
    dpd_pkg::vec3_t     aja_reg;
    dpd_pkg::vec3_t     dvb_reg;
    dpd_pkg::vec3_t     pb_reg;
    dpd_pkg::vec3_t     nfb_reg;
    dpd_pkg::vec3_t     aib_reg;
    dpd_pkg::vec3_t     ajb_reg;
    dpd_pkg::result_t   result_reg;

    assign adv          = !(valid_reg[ST_OUT] && result_stall);
    assign ctrl.adv     = adv;
    assign pair_stall   = !adv;
    assign result_valid = valid_reg[ST_OUT];
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            cutoff_sq_reg <= 31'd16777216;
            cutoff_reg    <= 31'd16777216;
            noise_reg     <= 31'd16777216;
            dt_reg        <= 31'd167772;
            dt_root_reg   <= 31'd1677721;
            inv_temp_reg  <= 31'd16777216;
            inv_kb_reg    <= 31'd16777216;
            f2v_reg       <= 31'd16777216;
        end
        else
        begin
            if (adv)
            begin
                valid_reg <= {valid_reg[ST_OUT-1:0], pair_valid};
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (dpd_pkg::cfg_index_t'(cfg_index))
                    dpd_pkg::CFG_CUTOFF_SQ:         cutoff_sq_reg <= cfg_data;
                    dpd_pkg::CFG_CUTOFF:            cutoff_reg    <= cfg_data;
                    dpd_pkg::CFG_NOISE_AMPLITUDE:   noise_reg     <= cfg_data;
                    dpd_pkg::CFG_TIME_STEP:         dt_reg        <= cfg_data;
                    dpd_pkg::CFG_TIME_STEP_ROOT:    dt_root_reg   <= cfg_data;
                    dpd_pkg::CFG_INV_TEMPERATURE:   inv_temp_reg  <= cfg_data;
                    dpd_pkg::CFG_INV_BOLTZMANN:     inv_kb_reg    <= cfg_data;
                    dpd_pkg::CFG_FORCE_TO_VELOCITY: f2v_reg       <= cfg_data;
                endcase
            end
        end
    end

    // pair-independent noise and friction factors
    always_ff @(posedge clk)
    begin
        hs_reg  <= dpd_pkg::fmul({1'b0, noise_reg}, dpd_pkg::FX_HALF);
        hs2_reg <= dpd_pkg::fmul(hs_reg, hs_reg);
        hgk_reg <= dpd_pkg::fmul(hs2_reg, {1'b0, inv_kb_reg});
        hg_reg  <= dpd_pkg::fmul(hgk_reg, {1'b0, inv_temp_reg});
    end

    assign rsq_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
    assign hit_next = (rsq_next != 64'd0) && (rsq_next < {9'd0, cutoff_sq_reg, 24'd0});

    always_comb
    begin
        for (int j = 1; j <= dpd_pkg::SQRT_STEPS; j++)
        begin
            logic [34:0] cur;
            logic [34:0] t;
            logic        ge;
            cur = {sq_rem_reg[j-1], sq_v_reg[j-1][63:62]};
            t   = {1'b0, sq_root_reg[j-1], 2'b01};
            ge  = cur >= t;
            sq_rem_next[j]  = ge ? 33'(cur - t) : cur[32:0];
            sq_root_next[j] = {sq_root_reg[j-1][30:0], ge};
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        dpd_fdiv u_axis_div (
            .clk     (clk),
            .ctrl    (ctrl),
            .num_mag (dpd_pkg::abs32(d_reg[ST_ROOT][k])),
            .den_mag (sq_root_reg[dpd_pkg::SQRT_STEPS]),
            .neg     (d_reg[ST_ROOT][k][31]),
            .quo     (n_quo[k])
        );
    end

    dpd_fdiv u_range_div (
        .clk     (clk),
        .ctrl    (ctrl),
        .num_mag (sq_root_reg[dpd_pkg::SQRT_STEPS]),
        .den_mag ({1'b0, cutoff_reg}),
        .neg     (1'b0),
        .quo     (q_quo)
    );

    dpd_fdiv u_corr_div (
        .clk     (clk),
        .ctrl    (ctrl),
        .num_mag (dpd_pkg::FX_ONE),
        .den_mag (dpd_pkg::abs32(den_reg)),
        .neg     (den_reg[31]),
        .quo     (c_quo)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg[0]           <= {pair.sep_z, pair.sep_y, pair.sep_x};
            vel_reg[0].vi      <= {pair.vel_iz, pair.vel_iy, pair.vel_ix};
            vel_reg[0].vj      <= {pair.vel_jz, pair.vel_jy, pair.vel_jx};
            side_reg[0].mi     <= pair.inv_mass_i;
            side_reg[0].mj     <= pair.inv_mass_j;
            side_reg[0].g      <= pair.gauss_sample;
            side_reg[0].hit    <= 1'b0;
            for (int i = 1; i <= ST_ROOT; i++)
            begin
                d_reg[i] <= d_reg[i-1];
            end
            for (int i = 1; i <= ST_A3; i++)
            begin
                vel_reg[i] <= vel_reg[i-1];
            end
            for (int i = 1; i <= ST_B6; i++)
            begin
                if (i == ST_RSQ)
                begin
                    side_reg[i] <= {side_reg[i-1].mi, side_reg[i-1].mj,
                                    side_reg[i-1].g, hit_next};
                end
                else
                begin
                    side_reg[i] <= side_reg[i-1];
                end
            end

            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= 64'(dpd_pkg::abs32(d_reg[ST_SQ-1][k]))
                             * 64'(dpd_pkg::abs32(d_reg[ST_SQ-1][k]));
            end

            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_v_reg[0]    <= rsq_next;
            for (int j = 1; j <= dpd_pkg::SQRT_STEPS; j++)
            begin
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_root_reg[j] <= sq_root_next[j];
                sq_v_reg[j]    <= {sq_v_reg[j-1][61:0], 2'b00};
            end

            // zero axis on a miss leaves the velocities untouched
            n_reg[ST_N] <= side_reg[ST_NDIV].hit ? n_quo : '0;
            for (int i = ST_N + 1; i <= ST_FB; i++)
            begin
                n_reg[i] <= n_reg[i-1];
            end
            wr_reg <= dpd_pkg::sub_sat(dpd_pkg::FX_ONE, q_quo);

            ww_reg  <= dpd_pkg::fmul(wr_reg, wr_reg);
            hsw_reg <= dpd_pkg::fmul(hs_reg, wr_reg);
            for (int k = 0; k < 3; k++)
            begin
                dv_reg[k] <= dpd_pkg::sub_sat(vel_reg[ST_N].vi[k], vel_reg[ST_N].vj[k]);
            end

            wdt_reg  <= dpd_pkg::fmul(ww_reg, {1'b0, dt_reg});
            hswt_reg <= dpd_pkg::fmul(hsw_reg, {1'b0, dt_root_reg});
            for (int k = 0; k < 3; k++)
            begin
                pa_reg[k] <= dpd_pkg::fmul(n_reg[ST_W1][k], dv_reg[k]);
            end

            hgw_reg   <= dpd_pkg::fmul(hg_reg, wdt_reg);
            hswtf_reg <= dpd_pkg::fmul(hswt_reg, {1'b0, f2v_reg});
            dota_reg  <= dpd_pkg::sum3_sat(pa_reg[0], pa_reg[1], pa_reg[2]);

            gf_reg[ST_GF] <= dpd_pkg::fmul(hgw_reg, {1'b0, f2v_reg});
            sr_reg[ST_GF] <= dpd_pkg::fmul(hswtf_reg, side_reg[ST_W3].g);
            dota2_reg     <= dota_reg;
            for (int i = ST_GF + 1; i <= ST_B2; i++)
            begin
                gf_reg[i] <= gf_reg[i-1];
            end
            for (int i = ST_GF + 1; i <= ST_B3; i++)
            begin
                sr_reg[i] <= sr_reg[i-1];
            end

            mgf_reg <= dpd_pkg::fmul(dpd_pkg::add_sat({1'b0, side_reg[ST_GF].mi},
                                                      {1'b0, side_reg[ST_GF].mj}),
                                     gf_reg[ST_GF]);
            fga_reg <= dpd_pkg::fmul(gf_reg[ST_GF], dota2_reg);

            den_reg <= dpd_pkg::add_sat(dpd_pkg::FX_ONE, mgf_reg);
            fa_reg  <= dpd_pkg::sub_sat(sr_reg[ST_A0], fga_reg);

            for (int k = 0; k < 3; k++)
            begin
                nfa_reg[k] <= dpd_pkg::fmul(n_reg[ST_A1][k], fa_reg);
                aia_reg[k] <= dpd_pkg::fmul(nfa_reg[k], {1'b0, side_reg[ST_A2].mi});
                aja_reg[k] <= dpd_pkg::fmul(nfa_reg[k], {1'b0, side_reg[ST_A2].mj});
                v1_reg[ST_A4].vi[k] <= dpd_pkg::add_sat(vel_reg[ST_A3].vi[k], aia_reg[k]);
                v1_reg[ST_A4].vj[k] <= dpd_pkg::sub_sat(vel_reg[ST_A3].vj[k], aja_reg[k]);
                dvb_reg[k] <= dpd_pkg::sub_sat(v1_reg[ST_A4].vi[k], v1_reg[ST_A4].vj[k]);
                pb_reg[k]  <= dpd_pkg::fmul(n_reg[ST_B0][k], dvb_reg[k]);
            end
            for (int i = ST_A4 + 1; i <= ST_B6; i++)
            begin
                v1_reg[i] <= v1_reg[i-1];
            end

            dotb_reg      <= dpd_pkg::sum3_sat(pb_reg[0], pb_reg[1], pb_reg[2]);
            fgb_reg       <= dpd_pkg::fmul(gf_reg[ST_B2], dotb_reg);
            sb_reg[ST_B4] <= dpd_pkg::sub_sat(sr_reg[ST_B3], fgb_reg);
            for (int i = ST_B4 + 1; i <= ST_CDIV; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end

            fb_reg <= dpd_pkg::fmul(sb_reg[ST_CDIV], c_quo);
            for (int k = 0; k < 3; k++)
            begin
                nfb_reg[k] <= dpd_pkg::fmul(n_reg[ST_FB][k], fb_reg);
                aib_reg[k] <= dpd_pkg::fmul(nfb_reg[k], {1'b0, side_reg[ST_B5].mi});
                ajb_reg[k] <= dpd_pkg::fmul(nfb_reg[k], {1'b0, side_reg[ST_B5].mj});
            end

            result_reg.new_ix     <= dpd_pkg::add_sat(v1_reg[ST_B6].vi[0], aib_reg[0]);
            result_reg.new_iy     <= dpd_pkg::add_sat(v1_reg[ST_B6].vi[1], aib_reg[1]);
            result_reg.new_iz     <= dpd_pkg::add_sat(v1_reg[ST_B6].vi[2], aib_reg[2]);
            result_reg.new_jx     <= dpd_pkg::sub_sat(v1_reg[ST_B6].vj[0], ajb_reg[0]);
            result_reg.new_jy     <= dpd_pkg::sub_sat(v1_reg[ST_B6].vj[1], ajb_reg[1]);
            result_reg.new_jz     <= dpd_pkg::sub_sat(v1_reg[ST_B6].vj[2], ajb_reg[2]);
            result_reg.interacted <= side_reg[ST_B6].hit;
        end
    end

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pair_valid && !pair_stall) |=> valid_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(valid_reg))
        else $error("pipeline moved while the result was stalled");

    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_ROOT] && side_reg[ST_ROOT].hit)
        |-> (sq_root_reg[dpd_pkg::SQRT_STEPS] != 32'd0))
        else $error("zero distance reached the axis divider on an interacting pair");

    a_den_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_A1] && side_reg[ST_A1].hit) |-> !den_reg[31])
        else $error("implicit correction denominator went negative");

endmodule

`default_nettype wire

/* hw/rtl/dpd_fdiv.sv */
// Pipelined Q8.24 quotient (a * 2^24) / b, truncated toward zero and clamped.
// One quotient bit per stage; depends on dpd_pkg.
`default_nettype none

module dpd_fdiv (
    input  wire logic               clk,
    input  wire dpd_pkg::pipe_ctrl_t ctrl,
    input  wire logic [31:0]        num_mag,
    input  wire logic [31:0]        den_mag,
    input  wire logic               neg,
    output logic signed [31:0]      quo
);

    logic [31:0] rem_reg [0:dpd_pkg::DIV_STEPS];
    logic [31:0] lo_reg  [0:dpd_pkg::DIV_STEPS];
    logic [31:0] q_reg   [0:dpd_pkg::DIV_STEPS];
    logic [31:0] den_reg [0:dpd_pkg::DIV_STEPS];
    logic        ovf_reg [0:dpd_pkg::DIV_STEPS];
    logic        neg_reg [0:dpd_pkg::DIV_STEPS];

    logic [31:0] rem_next [1:dpd_pkg::DIV_STEPS];
    logic [31:0] q_next   [1:dpd_pkg::DIV_STEPS];

    logic        ovf_next;

    assign ovf_next = {8'd0, num_mag[31:8]} >= den_mag;

    always_comb
    begin
        for (int i = 1; i <= dpd_pkg::DIV_STEPS; i++)
        begin
            logic [32:0] t;
            logic        ge;
            t  = {rem_reg[i-1], lo_reg[i-1][31]};
            ge = t >= {1'b0, den_reg[i-1]};
            rem_next[i] = ge ? 32'(t - {1'b0, den_reg[i-1]}) : t[31:0];
            q_next[i]   = {q_reg[i-1][30:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            rem_reg[0] <= ovf_next ? 32'd0 : {8'd0, num_mag[31:8]};
            lo_reg[0]  <= {num_mag[7:0], 24'd0};
            q_reg[0]   <= '0;
            den_reg[0] <= den_mag;
            ovf_reg[0] <= ovf_next;
            neg_reg[0] <= neg;
            for (int i = 1; i <= dpd_pkg::DIV_STEPS; i++)
            begin
                rem_reg[i] <= rem_next[i];
                lo_reg[i]  <= {lo_reg[i-1][30:0], 1'b0};
                q_reg[i]   <= q_next[i];
                den_reg[i] <= den_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    always_comb
    begin
        if (ovf_reg[dpd_pkg::DIV_STEPS])
        begin
            quo = neg_reg[dpd_pkg::DIV_STEPS] ? dpd_pkg::FX_MIN : dpd_pkg::FX_MAX;
        end
        else if (!neg_reg[dpd_pkg::DIV_STEPS])
        begin
            quo = q_reg[dpd_pkg::DIV_STEPS][31] ? dpd_pkg::FX_MAX
                                                : q_reg[dpd_pkg::DIV_STEPS];
        end
        else
        begin
            quo = (q_reg[dpd_pkg::DIV_STEPS] > 32'h8000_0000) ? dpd_pkg::FX_MIN
                  : 32'(-q_reg[dpd_pkg::DIV_STEPS]);
        end
    end

endmodule

`default_nettype wire

/* tb/dpd_pair_velocity_update_unit_test.sv */
// Self-checking test of dpd_pair_velocity_update_unit: random and directed pairs,
// predicted in Q8.24 and compared field by field with each result transaction.
// Depends on dpd_pkg and the RTL of the unit.
`default_nettype none

module dpd_pair_velocity_update_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dpd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        pair_valid;
    logic        pair_stall;
    pair_t       pair;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [30:0] cfg_data;

    dpd_pair_velocity_update_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .pair_valid(pair_valid), .pair_stall(pair_stall), .pair(pair),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    longint reg_val [8];
    pair_t   pending_pairs [$];
    result_t expected_velocities [$];
    int      mismatches;
    bit      no_idle;
    bit      hold_long;
    int      send_gap;
    int      recv_gap;
    int      hold_cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint clamp(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b + 64'sd8388608;
        return clamp(p >>> 24);
    endfunction

    function automatic longint qdiv(longint a, longint b);
        if (b == 0) return (a >= 0) ? 64'sd2147483647 : -64'sd2147483648;
        return clamp((a * 64'sd16777216) / b);
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
            begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint axial_rate(longint n[3], longint vi[3], longint vj[3]);
        longint s;
        s = 0;
        for (int k = 0; k < 3; k++) s += qmul(n[k], clamp(vi[k] - vj[k]));
        return clamp(s);
    endfunction

    function automatic result_t predict_velocities(pair_t p);
        longint d[3], vi[3], vj[3], n[3];
        longint mi, mj, g, r, wr, wdt, hs, hg, sr, gf, den, c, f, nf;
        longint unsigned rsq, a;
        bit hit;
        result_t res;
        d = '{longint'(p.sep_x), longint'(p.sep_y), longint'(p.sep_z)};
        vi = '{longint'(p.vel_ix), longint'(p.vel_iy), longint'(p.vel_iz)};
        vj = '{longint'(p.vel_jx), longint'(p.vel_jy), longint'(p.vel_jz)};
        mi = longint'({33'd0, p.inv_mass_i});
        mj = longint'({33'd0, p.inv_mass_j});
        g = longint'(p.gauss_sample);
        rsq = 0;
        for (int k = 0; k < 3; k++)
        begin
            a = (d[k] < 0) ? longint'(-d[k]) : longint'(d[k]);
            rsq += a * a;
        end
        hit = (rsq != 0) && (rsq < (longint'(reg_val[CFG_CUTOFF_SQ]) << 24));
        if (hit)
        begin
            r = isqrt(rsq);
            for (int k = 0; k < 3; k++) n[k] = qdiv(d[k], r);
            wr = clamp(64'sd16777216 - qdiv(r, reg_val[CFG_CUTOFF]));
            wdt = qmul(qmul(wr, wr), reg_val[CFG_TIME_STEP]);
            hs = qmul(reg_val[CFG_NOISE_AMPLITUDE], 64'sd8388608);
            hg = qmul(qmul(qmul(hs, hs), reg_val[CFG_INV_BOLTZMANN]),
                      reg_val[CFG_INV_TEMPERATURE]);
            sr = qmul(qmul(qmul(qmul(hs, wr), reg_val[CFG_TIME_STEP_ROOT]),
                           reg_val[CFG_FORCE_TO_VELOCITY]), g);
            gf = qmul(qmul(hg, wdt), reg_val[CFG_FORCE_TO_VELOCITY]);
            den = clamp(64'sd16777216 + qmul(clamp(mi + mj), gf));
            c = qdiv(64'sd16777216, den);
            for (int stage = 0; stage < 2; stage++)
            begin
                f = clamp(sr - qmul(gf, axial_rate(n, vi, vj)));
                if (stage == 1) f = qmul(f, c);
                for (int k = 0; k < 3; k++)
                begin
                    nf = qmul(n[k], f);
                    vi[k] = clamp(vi[k] + qmul(nf, mi));
                    vj[k] = clamp(vj[k] - qmul(nf, mj));
                end
            end
        end
        res.new_ix = vi[0][31:0];
        res.new_iy = vi[1][31:0];
        res.new_iz = vi[2][31:0];
        res.new_jx = vj[0][31:0];
        res.new_jy = vj[1][31:0];
        res.new_jz = vj[2][31:0];
        res.interacted = hit;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid <= 1'b0;
            pair <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (pair_valid && !pair_stall)
            begin
                expected_velocities.push_back(predict_velocities(pair));
            end
            if (!pair_valid || !pair_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    pair_valid <= 1'b0;
                end
                else if (pending_pairs.size() > 0)
                begin
                    pair <= pending_pairs.pop_front();
                    pair_valid <= 1'b1;
                    if (!no_idle && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 9);
                end
                else
                begin
                    pair_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            recv_gap <= 0;
            hold_cycles <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_velocities.size() == 0)
                begin
                    report_mismatch("unexpected result", result.new_ix, 32'd0);
                end
                else
                begin
                    want = expected_velocities.pop_front();
                    if (result.new_ix !== want.new_ix)
                        report_mismatch("new_ix", result.new_ix, want.new_ix);
                    if (result.new_iy !== want.new_iy)
                        report_mismatch("new_iy", result.new_iy, want.new_iy);
                    if (result.new_iz !== want.new_iz)
                        report_mismatch("new_iz", result.new_iz, want.new_iz);
                    if (result.new_jx !== want.new_jx)
                        report_mismatch("new_jx", result.new_jx, want.new_jx);
                    if (result.new_jy !== want.new_jy)
                        report_mismatch("new_jy", result.new_jy, want.new_jy);
                    if (result.new_jz !== want.new_jz)
                        report_mismatch("new_jz", result.new_jz, want.new_jz);
                    if (result.interacted !== want.interacted)
                        report_mismatch("interacted", 32'(result.interacted),
                                        32'(want.interacted));
                end
            end
            if (hold_long && hold_cycles == 0)
            begin
                hold_cycles <= 400;
                result_stall <= 1'b1;
            end
            else if (hold_cycles > 1)
            begin
                hold_cycles <= hold_cycles - 1;
                result_stall <= 1'b1;
            end
            else if (hold_cycles == 1)
            begin
                if (!hold_long) hold_cycles <= 0;
                result_stall <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                result_stall <= (recv_gap > 1);
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                recv_gap <= $urandom_range(1, 9);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    task automatic write_register(cfg_index_t idx, longint value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[30:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_val[idx] = value & 64'h7FFF_FFFF;
    endtask

    task automatic drain_pipeline();
        wait (pending_pairs.size() == 0 && !pair_valid && expected_velocities.size() == 0);
        repeat (130) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 33554432)) - 16777216);
            default: return $urandom;
        endcase
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int scale;
        p.vel_ix = rand_word();
        p.vel_iy = rand_word();
        p.vel_iz = rand_word();
        p.vel_jx = rand_word();
        p.vel_jy = rand_word();
        p.vel_jz = rand_word();
        p.inv_mass_i = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 50331648));
        p.inv_mass_j = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 50331648));
        p.gauss_sample = ($urandom_range(0, 3) == 0) ? 32'($urandom)
                         : 32'(int'($urandom_range(0, 100663296)) - 50331648);
        if ($urandom_range(0, 4) == 0)
        begin
            p.sep_x = $urandom;
            p.sep_y = $urandom;
            p.sep_z = $urandom;
        end
        else
        begin
            scale = $urandom_range(0, 24);
            p.sep_x = 32'(int'($urandom_range(0, 2 ** scale)) - 2 ** (scale - 1));
            p.sep_y = 32'(int'($urandom_range(0, 2 ** scale)) - 2 ** (scale - 1));
            p.sep_z = 32'(int'($urandom_range(0, 2 ** scale)) - 2 ** (scale - 1));
        end
        return p;
    endfunction

    function automatic pair_t make_pair(int sx, int sy, int sz, int v, int m, int g);
        pair_t p;
        p.sep_x = sx;
        p.sep_y = sy;
        p.sep_z = sz;
        p.vel_ix = v;
        p.vel_iy = -v;
        p.vel_iz = v;
        p.vel_jx = -v;
        p.vel_jy = v;
        p.vel_jz = 0;
        p.inv_mass_i = 31'(m);
        p.inv_mass_j = 31'(m);
        p.gauss_sample = g;
        return p;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pair_valid = 1'b0;
        pair = '0;
        result_stall = 1'b0;
        mismatches = 0;
        no_idle = 1'b0;
        hold_long = 1'b0;
        reg_val = '{16777216, 16777216, 16777216, 167772, 1677721,
                    16777216, 16777216, 16777216};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: coincident, in range, at cutoff, extremes, saturation
        pending_pairs.push_back(make_pair(0, 0, 0, 1000, 16777216, 16777216));
        pending_pairs.push_back(make_pair(8388608, 0, 0, 16777216, 16777216, 16777216));
        pending_pairs.push_back(make_pair(0, -8388608, 4194304, -16777216, 33554432, -16777216));
        pending_pairs.push_back(make_pair(16777216, 0, 0, 100, 16777216, 16777216));
        pending_pairs.push_back(make_pair(16777215, 0, 0, 100, 16777216, 16777216));
        pending_pairs.push_back(make_pair(1, 0, 0, 2147483647, 2147483647, 2147483647));
        pending_pairs.push_back(make_pair(0, 0, -1, -2147483648, 2147483647, -2147483648));
        pending_pairs.push_back(make_pair(-2147483648, -2147483648, -2147483648, 5, 1, 1));
        pending_pairs.push_back(make_pair(2147483647, 2147483647, 2147483647, 5, 1, 1));
        pending_pairs.push_back(make_pair(5000000, 5000000, 5000000, 2147483647, 0, 0));
        pending_pairs.push_back(make_pair(100, -100, 100, 1 << 30, 2147483647, 2147483647));
        drain_pipeline();

        write_register(CFG_CUTOFF_SQ, 64'h7FFF_FFFF);
        write_register(CFG_CUTOFF, 0);
        write_register(CFG_NOISE_AMPLITUDE, 64'h7FFF_FFFF);
        write_register(CFG_TIME_STEP, 64'h7FFF_FFFF);
        write_register(CFG_TIME_STEP_ROOT, 64'h7FFF_FFFF);
        write_register(CFG_INV_TEMPERATURE, 64'h7FFF_FFFF);
        write_register(CFG_INV_BOLTZMANN, 64'h7FFF_FFFF);
        write_register(CFG_FORCE_TO_VELOCITY, 64'h7FFF_FFFF);
        pending_pairs.push_back(make_pair(8388608, 0, 0, 16777216, 16777216, 16777216));
        pending_pairs.push_back(make_pair(1 << 28, 1 << 28, 0, -7, 2147483647, -16777216));
        for (int i = 0; i < 300; i++) pending_pairs.push_back(random_pair());
        drain_pipeline();

        write_register(CFG_CUTOFF_SQ, 0);
        write_register(CFG_CUTOFF, 1);
        write_register(CFG_NOISE_AMPLITUDE, 0);
        write_register(CFG_TIME_STEP, 0);
        write_register(CFG_TIME_STEP_ROOT, 0);
        write_register(CFG_INV_TEMPERATURE, 0);
        write_register(CFG_INV_BOLTZMANN, 0);
        write_register(CFG_FORCE_TO_VELOCITY, 0);
        for (int i = 0; i < 100; i++) pending_pairs.push_back(random_pair());
        drain_pipeline();

        write_register(CFG_CUTOFF_SQ, 64'd67108864);
        write_register(CFG_CUTOFF, 64'd16777216);
        write_register(CFG_NOISE_AMPLITUDE, 64'd50331648);
        write_register(CFG_TIME_STEP, 64'd167772);
        write_register(CFG_TIME_STEP_ROOT, 64'd1677721);
        write_register(CFG_INV_TEMPERATURE, 64'd16777216);
        write_register(CFG_INV_BOLTZMANN, 64'd16777216);
        write_register(CFG_FORCE_TO_VELOCITY, 64'd16777216);
        for (int i = 0; i < 300; i++) pending_pairs.push_back(random_pair());
        hold_long = 1'b1;
        wait (pair_valid && pair_stall);
        hold_long = 1'b0;
        drain_pipeline();

        for (int phase = 0; phase < 3; phase++)
        begin
            for (int idx = 0; idx < 8; idx++)
                write_register(cfg_index_t'(idx), (idx == 1) ? $urandom_range(1, 64'h7FFF_FFFF)
                               : $urandom_range(0, 64'd100000000));
            if (phase == 2) no_idle = 1'b1;
            for (int i = 0; i < 270; i++) pending_pairs.push_back(random_pair());
            drain_pipeline();
        end

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
